@@ sv/vlit_pkg.sv @@
// Shared types and constants for the vector linear interpolation table.
package vlit_pkg;

    localparam int MAX_POINTS_DEF     = 256;
    localparam int MAX_COMPONENTS_DEF = 8;
    localparam int FRAC_BITS_DEF      = 16;

    localparam logic [1:0] REQ_WR_POINT = 2'd0;
    localparam logic [1:0] REQ_WR_COMP  = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;

    localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [1:0] CFG_COMPONENTS  = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         point_index;
        logic [2:0]         component_index;
        logic signed [31:0] point_value;
        logic signed [31:0] component_value;
        logic signed [31:0] query_point;
    } req_t;

    typedef struct packed {
        logic [2:0]         out_component;
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic               last;
    } res_t;

endpackage

@@ sv/vlit_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vlit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ sv/vlit_div.sv @@
// Restoring divider for the interpolation weight, one quotient bit per cycle.
module vlit_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [31:0]          num,
    input  logic [31:0]          den,
    output logic                 busy,
    output logic                 done,
    output logic [FRAC_BITS-1:0] quot
);
    localparam int CNTW = $clog2(FRAC_BITS + 1);

    logic [31:0]     rem_reg;
    logic [31:0]     den_reg;
    logic [FRAC_BITS-1:0] quot_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [32:0]     rem2;
    logic            fits;

    assign rem2 = {rem_reg, 1'b0};
    assign fits = rem2 >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num;
                den_reg  <= den;
                quot_reg <= '0;
                cnt_reg  <= CNTW'(FRAC_BITS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // remainder stays below den, so the low 32 bits hold it
                rem_reg  <= fits ? 32'(rem2 - {1'b0, den_reg}) : rem2[31:0];
                quot_reg <= {quot_reg[FRAC_BITS-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
endmodule

@@ sv/vector_linear_interpolation_table.sv @@
// Vector piecewise-linear interpolation table, Q16.16, top level.
// A query reads the last and first breakpoints for the edge checks, then binary
// searches (up to log2(point_count)+1 steps), reads the segment ends, sets up and
// runs the divider, then reads, multiplies and sums each component in turn. Output
// stalls hold it, and no new request is taken until its last beat is loaded. Edge
// rows skip the search. Sync aresetn resets control and registers, not tables.
module vector_linear_interpolation_table #(
    parameter int MAX_POINTS     = vlit_pkg::MAX_POINTS_DEF,
    parameter int MAX_COMPONENTS = vlit_pkg::MAX_COMPONENTS_DEF,
    parameter int FRAC_BITS      = vlit_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  vlit_pkg::req_t  s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output vlit_pkg::res_t  m_payload,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import vlit_pkg::*;

    localparam int PW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = $clog2(MAX_COMPONENTS + 1);
    localparam int CD  = MAX_POINTS * MAX_COMPONENTS;
    localparam int CAW = $clog2(CD);
    localparam int PRW = FRAC_BITS + 35;
    localparam int SW  = FRAC_BITS + 37;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_LAST, S_RD_FIRST, S_CHK, S_ERR, S_SEARCH, S_SCMP,
        S_RD_TP, S_RD_TN, S_DIVSET, S_DIV, S_CRA, S_CRB, S_CMUL, S_CSUM
    } state_t;

    state_t state_reg;

    logic [8:0]  pc_reg;
    logic [3:0]  cpp_reg;
    logic [30:0] tol_reg;

    logic signed [31:0] t_reg, last_reg, tp_reg, vp_reg;
    logic [NW-1:0]      lo_reg, hi_reg;
    logic [PW-1:0]      mid_reg, row_lo_reg, row_hi_reg;
    logic [FRAC_BITS:0] lambda_reg;
    logic [CW-1:0]      comp_reg;
    logic signed [PRW-1:0] prod_reg;
    logic [1:0]         err_reg;
    logic               m_valid_reg;
    res_t               m_payload_reg;

    logic [NW-1:0] n_cl;
    logic [CW-1:0] m_cl;
    logic [PW-1:0] n_m1;
    logic          s_acc, out_free, out_load;

    // clamp register values to the table size
    always_comb begin
        if (pc_reg == '0) begin
            n_cl = NW'(1);
        end else if (32'(pc_reg) > MAX_POINTS) begin
            n_cl = NW'(MAX_POINTS);
        end else begin
            n_cl = NW'(pc_reg);
        end
        if (cpp_reg == '0) begin
            m_cl = CW'(1);
        end else if (32'(cpp_reg) > MAX_COMPONENTS) begin
            m_cl = CW'(MAX_COMPONENTS);
        end else begin
            m_cl = CW'(cpp_reg);
        end
    end
    assign n_m1 = PW'(n_cl - NW'(1));

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = out_free && (state_reg == S_ERR || state_reg == S_CSUM);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= 9'd1;
            cpp_reg <= 4'd1;
            tol_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_POINT_COUNT: pc_reg  <= cfg_data[8:0];
                CFG_COMPONENTS:  cpp_reg <= cfg_data[3:0];
                CFG_TOLERANCE:   tol_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // breakpoint memory
    logic          bp_wr_en, bp_rd_en;
    logic [PW-1:0] bp_rd_addr;
    logic [31:0]   bp_rd_data;
    logic [NW:0]   mid_sum;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign bp_wr_en = s_acc && s_payload.req_type == REQ_WR_POINT
                      && 32'(s_payload.point_index) < MAX_POINTS;

    always_comb begin
        bp_rd_en   = 1'b0;
        bp_rd_addr = '0;
        case (state_reg)
            S_RD_LAST: begin
                bp_rd_en   = 1'b1;
                bp_rd_addr = n_m1;
            end
            S_RD_FIRST: bp_rd_en = 1'b1;
            S_SEARCH: begin
                bp_rd_en   = lo_reg < hi_reg;
                bp_rd_addr = PW'(mid_sum >> 1);
            end
            S_RD_TP: begin
                bp_rd_en   = 1'b1;
                bp_rd_addr = row_lo_reg;
            end
            S_RD_TN: begin
                bp_rd_en   = 1'b1;
                bp_rd_addr = row_hi_reg;
            end
            default: ;
        endcase
    end

    vlit_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_bp_ram (
        .aclk    (aclk),
        .wr_en   (bp_wr_en),
        .wr_addr (PW'(s_payload.point_index)),
        .wr_data (s_payload.point_value),
        .rd_en   (bp_rd_en),
        .rd_addr (bp_rd_addr),
        .rd_data (bp_rd_data)
    );

    // component memory, MAX_COMPONENTS entries per breakpoint
    logic           cv_wr_en, cv_rd_en;
    logic [CAW-1:0] cv_wr_addr, cv_rd_addr;
    logic [31:0]    cv_rd_data;

    assign cv_wr_en = s_acc && s_payload.req_type == REQ_WR_COMP
                      && 32'(s_payload.point_index) < MAX_POINTS
                      && 32'(s_payload.component_index) < MAX_COMPONENTS;
    assign cv_wr_addr = CAW'(CAW'(s_payload.point_index) * CAW'(MAX_COMPONENTS)
                        + CAW'(s_payload.component_index));
    assign cv_rd_en   = (state_reg == S_CRA) || (state_reg == S_CRB);
    assign cv_rd_addr = CAW'(CAW'((state_reg == S_CRB) ? row_hi_reg : row_lo_reg)
                        * CAW'(MAX_COMPONENTS) + CAW'(comp_reg));

    vlit_ram #(.WIDTH(32), .DEPTH(CD)) u_cv_ram (
        .aclk    (aclk),
        .wr_en   (cv_wr_en),
        .wr_addr (cv_wr_addr),
        .wr_data (s_payload.component_value),
        .rd_en   (cv_rd_en),
        .rd_addr (cv_rd_addr),
        .rd_data (cv_rd_data)
    );

    // weight divider
    logic signed [32:0] num_w, den_w;
    logic               div_start, div_busy, div_done;
    logic [FRAC_BITS-1:0] div_quot;

    assign num_w = 33'(t_reg) - 33'(tp_reg);
    assign den_w = 33'($signed(bp_rd_data)) - 33'(tp_reg);
    assign div_start = (state_reg == S_DIVSET) && den_w > 0 && num_w > 0
                       && num_w < den_w;

    vlit_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_w[31:0]),
        .den     (den_w[31:0]),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // edge tests
    logic signed [33:0] t_x, last_hi, first_lo, first_x;
    assign t_x      = 34'(t_reg);
    assign first_x  = 34'($signed(bp_rd_data));
    assign last_hi  = 34'(last_reg) + $signed({3'b000, tol_reg});
    assign first_lo = first_x - $signed({3'b000, tol_reg});

    // search result clamp
    logic [NW-1:0] i_w;
    always_comb begin
        i_w = lo_reg;
        if (lo_reg > NW'(n_m1)) begin
            i_w = NW'(n_m1);
        end
        if (i_w < NW'(1)) begin
            i_w = NW'(1);
        end
    end

    // interpolation datapath
    logic signed [32:0]   diff_w;
    logic signed [SW-1:0] sum_w, shr_w;
    logic signed [31:0]   res_w;
    assign diff_w = 33'($signed(cv_rd_data)) - 33'(vp_reg);
    assign sum_w  = (SW'(vp_reg) <<< FRAC_BITS) + SW'(prod_reg);
    assign shr_w  = sum_w >>> FRAC_BITS;
    always_comb begin
        if (shr_w > SW'(32'sh7fffffff)) begin
            res_w = 32'sh7fffffff;
        end else if (shr_w < -SW'(33'sh080000000)) begin
            res_w = 32'sh80000000;
        end else begin
            res_w = shr_w[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_payload.req_type == REQ_QUERY) begin
                        t_reg     <= s_payload.query_point;
                        state_reg <= S_RD_LAST;
                    end
                end
                S_RD_LAST:  state_reg <= S_RD_FIRST;
                S_RD_FIRST: begin
                    last_reg  <= $signed(bp_rd_data);
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    lambda_reg <= '0;
                    comp_reg   <= '0;
                    if (t_reg >= last_reg) begin
                        if (t_x > last_hi) begin
                            err_reg   <= ST_ABOVE;
                            state_reg <= S_ERR;
                        end else begin
                            row_lo_reg <= n_m1;
                            row_hi_reg <= n_m1;
                            state_reg  <= S_CRA;
                        end
                    end else if (t_x <= first_x) begin
                        if (t_x < first_lo) begin
                            err_reg   <= ST_BELOW;
                            state_reg <= S_ERR;
                        end else begin
                            row_lo_reg <= '0;
                            row_hi_reg <= '0;
                            state_reg  <= S_CRA;
                        end
                    end else begin
                        lo_reg    <= '0;
                        hi_reg    <= n_cl;
                        state_reg <= S_SEARCH;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        m_payload_reg <= '{out_component: 3'd0, result_value: 32'sd0,
                                           status: err_reg, last: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end
                S_SEARCH: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= PW'(mid_sum >> 1);
                        state_reg <= S_SCMP;
                    end else begin
                        row_hi_reg <= PW'(i_w);
                        row_lo_reg <= PW'(i_w - NW'(1));
                        state_reg  <= S_RD_TP;
                    end
                end
                S_SCMP: begin
                    if ($signed(bp_rd_data) < t_reg) begin
                        lo_reg <= NW'(mid_reg) + NW'(1);
                    end else begin
                        hi_reg <= NW'(mid_reg);
                    end
                    state_reg <= S_SEARCH;
                end
                S_RD_TP: state_reg <= S_RD_TN;
                S_RD_TN: begin
                    tp_reg    <= $signed(bp_rd_data);
                    state_reg <= S_DIVSET;
                end
                S_DIVSET: begin
                    if (den_w <= 0 || num_w <= 0) begin
                        lambda_reg <= '0;
                        state_reg  <= S_CRA;
                    end else if (num_w >= den_w) begin
                        lambda_reg <= {1'b1, {FRAC_BITS{1'b0}}};
                        state_reg  <= S_CRA;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        lambda_reg <= {1'b0, div_quot};
                        state_reg  <= S_CRA;
                    end
                end
                S_CRA: state_reg <= S_CRB;
                S_CRB: begin
                    vp_reg    <= $signed(cv_rd_data);
                    state_reg <= S_CMUL;
                end
                S_CMUL: begin
                    prod_reg  <= PRW'($signed({1'b0, lambda_reg})) * PRW'(diff_w);
                    state_reg <= S_CSUM;
                end
                S_CSUM: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        m_payload_reg <= '{out_component: 3'(comp_reg),
                                           result_value: res_w, status: ST_OK,
                                           last: comp_reg + CW'(1) == m_cl};
                        comp_reg <= comp_reg + CW'(1);
                        if (comp_reg + CW'(1) == m_cl) begin
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_CRA;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    property p_err_form;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != ST_OK |-> m_payload.last
            && m_payload.result_value == 32'sd0 && m_payload.out_component == 3'd0;
    endproperty
    a_err_form: assert property (p_err_form) else $error("malformed error beat");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");

    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SEARCH |-> lo_reg <= hi_reg && hi_reg <= n_cl)
        else $error("search bounds crossed");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && !div_done |-> div_busy)
        else $error("waiting on an idle divider");
endmodule

@@ tb/vector_linear_interpolation_table_tb.sv @@
// Self-checking testbench for the vector linear interpolation table.
module vector_linear_interpolation_table_tb;
    import vlit_pkg::*;

    localparam int NPTS      = MAX_POINTS_DEF;
    localparam int NCOMP     = MAX_COMPONENTS_DEF;
    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int IDLE_STOP = 6000;
    localparam int DRAIN_GAP = 100;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        req_t       req;
        bit         typed;
        bit         has_res;
        res_t       res;
        logic [1:0] cfg_idx;
        logic [31:0] cfg_val;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    req_t        s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    res_t        m_payload;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // mirror of the block's table and registers
    logic signed [31:0] point_tab [NPTS];
    logic signed [31:0] comp_tab  [NPTS][NCOMP];
    int                 pts_used;
    int                 comps_used;
    longint             slack;

    res_t      awaited_results[$];
    stim_row_t directed_rows[$];
    int        mismatches;
    int        queries_sent;
    int        writes_sent;
    int        results_seen;
    int        idle_cycles;
    int        stall_left;
    bit        calm;

    vector_linear_interpolation_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // append one expected beat to the scoreboard
    function automatic void queue_beat(input res_t x);
        awaited_results.insert(awaited_results.size(), x);
    endfunction

    function automatic req_t mk_req(input logic [1:0] kind, input logic [7:0] pidx,
                                    input logic [2:0] cidx, input logic [31:0] pval,
                                    input logic [31:0] cval, input logic [31:0] qpt);
        req_t r;
        r.req_type = kind;
        r.point_index = pidx;
        r.component_index = cidx;
        r.point_value = pval;
        r.component_value = cval;
        r.query_point = qpt;
        return r;
    endfunction

    function automatic res_t mk_res(input logic [2:0] comp, input logic [31:0] val,
                                    input logic [1:0] st, input logic lst);
        res_t x;
        x.out_component = comp;
        x.result_value = val;
        x.status = st;
        x.last = lst;
        return x;
    endfunction

    function automatic req_t rand_req(input logic [1:0] kind);
        return mk_req(kind, 8'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
    endfunction

    task automatic emit_stored_row(input int row);
        for (int c = 0; c < comps_used; c++)
            queue_beat(mk_res(3'(c), comp_tab[row][c], ST_OK, c == comps_used - 1));
    endtask

    // Apply one accepted request to the mirror and queue what it should produce.
    task automatic interpolate_expect(input req_t r);
        longint t, first, final_pt, tp, tn, num, den, lambda, vp, vn, acc;
        int lo, hi, mid, seg;
        case (r.req_type)
            REQ_WR_POINT: point_tab[r.point_index] = r.point_value;
            REQ_WR_COMP:  comp_tab[r.point_index][r.component_index] = r.component_value;
            REQ_QUERY: begin
                t = longint'(r.query_point);
                first = longint'(point_tab[0]);
                final_pt = longint'(point_tab[pts_used - 1]);
                if (t >= final_pt) begin
                    if (t > final_pt + slack)
                        queue_beat(mk_res(3'd0, 32'd0, ST_ABOVE, 1'b1));
                    else
                        emit_stored_row(pts_used - 1);
                end else if (t <= first) begin
                    if (t < first - slack)
                        queue_beat(mk_res(3'd0, 32'd0, ST_BELOW, 1'b1));
                    else
                        emit_stored_row(0);
                end else begin
                    lo = 0;
                    hi = pts_used;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (longint'(point_tab[mid]) < t) lo = mid + 1;
                        else hi = mid;
                    end
                    seg = lo;
                    if (seg > pts_used - 1) seg = pts_used - 1;
                    if (seg < 1) seg = 1;
                    tp = longint'(point_tab[seg - 1]);
                    tn = longint'(point_tab[seg]);
                    num = t - tp;
                    den = tn - tp;
                    if (den <= 0 || num <= 0) lambda = 0;
                    else if (num >= den) lambda = longint'(1) << FRAC;
                    else lambda = (num << FRAC) / den;
                    for (int c = 0; c < comps_used; c++) begin
                        vp = longint'(comp_tab[seg - 1][c]);
                        vn = longint'(comp_tab[seg][c]);
                        acc = (((longint'(1) << FRAC) - lambda) * vp + lambda * vn) >>> FRAC;
                        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                        queue_beat(mk_res(3'(c), acc[31:0], ST_OK, c == comps_used - 1));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_req(input req_t r, input bit typed, input bit has_res,
                            input res_t res);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        if (r.req_type == REQ_QUERY) queries_sent++;
        else if (r.req_type != REQ_RESERVED) writes_sent++;
        if (typed) begin
            if (has_res) queue_beat(res);
        end else begin
            interpolate_expect(r);
        end
    endtask

    task automatic send(input req_t r);
        send_req(r, 1'b0, 1'b0, '0);
    endtask

    // Let the block go idle: stop requests and wait until all results are back.
    task automatic drain();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POINT_COUNT: pts_used = (val[8:0] == 0) ? 1 :
                                        (val[8:0] > NPTS) ? NPTS : int'(val[8:0]);
            CFG_COMPONENTS:  comps_used = (val[3:0] == 0) ? 1 :
                                          (val[3:0] > NCOMP) ? NCOMP : int'(val[3:0]);
            CFG_TOLERANCE:   slack = longint'(val[30:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic add_req(input req_t r);
        stim_row_t row;
        row = '{kind: ROW_REQ, req: r, typed: 1'b0, has_res: 1'b0, res: '0,
                cfg_idx: '0, cfg_val: '0};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic add_typed(input req_t r, input bit has_res, input res_t res);
        stim_row_t row;
        row = '{kind: ROW_REQ, req: r, typed: 1'b1, has_res: has_res, res: res,
                cfg_idx: '0, cfg_val: '0};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t row;
        row = '{kind: ROW_CFG, req: '0, typed: 1'b0, has_res: 1'b0, res: '0,
                cfg_idx: idx, cfg_val: val};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic logic [31:0] pick_query();
        longint lo, hi, span;
        lo = longint'(point_tab[0]) - slack - 65536;
        hi = longint'(point_tab[pts_used - 1]) + slack + 65536;
        if (lo < -64'sd2147483648) lo = -64'sd2147483648;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        if (hi < lo) hi = lo;
        span = hi - lo + 1;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return point_tab[$urandom_range(0, pts_used - 1)];
            default: return 32'(lo + longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF)
                                % span);
        endcase
    endfunction

    task automatic run_phase(input logic [31:0] n_val, input logic [31:0] m_val,
                             input logic [31:0] tol_val, input bit unsorted,
                             input int queries);
        longint pos, step_max;
        drain();
        cfg_write(CFG_POINT_COUNT, n_val);
        cfg_write(CFG_COMPONENTS, m_val);
        cfg_write(CFG_TOLERANCE, tol_val);
        step_max = $urandom_range(0, 1) ? 64'd4294967295 / (pts_used + 1)
                                        : longint'($urandom_range(1, 32'h40000));
        pos = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF)) % (step_max + 1);
        for (int k = 0; k < pts_used; k++) begin
            send(mk_req(REQ_WR_POINT, 8'(k), 3'($urandom), unsorted ? $urandom : pos[31:0],
                        $urandom, $urandom));
            pos += longint'($urandom_range(0, 32'hFFFF_FFFF)) % (step_max + 1);
            for (int c = 0; c < comps_used; c++)
                send(mk_req(REQ_WR_COMP, 8'(k), 3'(c), $urandom, $urandom, $urandom));
        end
        for (int q = 0; q < queries; q++) begin
            case ($urandom_range(0, 11))
                0:       send(rand_req(REQ_RESERVED));
                1:       send(mk_req(REQ_WR_COMP, 8'($urandom_range(0, pts_used - 1)),
                                     3'($urandom_range(0, comps_used - 1)),
                                     $urandom, $urandom, $urandom));
                default: send(mk_req(REQ_QUERY, 8'($urandom), 3'($urandom), $urandom,
                                     $urandom, pick_query()));
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected beat %p", m_payload));
            end else begin
                want = awaited_results.pop_front();
                if (m_payload.out_component !== want.out_component)
                    report($sformatf("out_component %0d, want %0d",
                                     m_payload.out_component, want.out_component));
                if (m_payload.result_value !== want.result_value)
                    report($sformatf("result_value %h, want %h",
                                     m_payload.result_value, want.result_value));
                if (m_payload.status !== want.status)
                    report($sformatf("status %0d, want %0d", m_payload.status, want.status));
                if (m_payload.last !== want.last)
                    report($sformatf("last %b, want %b", m_payload.last, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_STOP) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     IDLE_STOP, awaited_results.size());
            $display("vector_linear_interpolation_table regression: fail");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        queries_sent = 0;
        writes_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        pts_used = 1;
        comps_used = 1;
        slack = 0;

        // reset defaults: one point, one component, no tolerance
        add_req(mk_req(REQ_WR_POINT, 8'h00, 3'h7, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_req(mk_req(REQ_WR_COMP, 8'h00, 3'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0));
        add_typed(mk_req(REQ_RESERVED, 8'hFF, 3'h7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF),
                  1'b0, '0);
        add_typed(mk_req(REQ_QUERY, 8'hFF, 3'h7, 32'h0, 32'h0, 32'h0),
                  1'b1, mk_res(3'd0, 32'h7FFF_FFFF, ST_OK, 1'b1));
        add_typed(mk_req(REQ_QUERY, 8'h00, 3'h0, 32'h0, 32'h0, 32'h1),
                  1'b1, mk_res(3'd0, 32'h0, ST_ABOVE, 1'b1));
        add_typed(mk_req(REQ_QUERY, 8'h00, 3'h0, 32'h0, 32'h0, 32'hFFFF_FFFF),
                  1'b1, mk_res(3'd0, 32'h0, ST_BELOW, 1'b1));
        add_typed(mk_req(REQ_QUERY, 8'h00, 3'h0, 32'h0, 32'h0, 32'h7FFF_FFFF),
                  1'b1, mk_res(3'd0, 32'h0, ST_ABOVE, 1'b1));
        add_typed(mk_req(REQ_QUERY, 8'h00, 3'h0, 32'h0, 32'h0, 32'h8000_0000),
                  1'b1, mk_res(3'd0, 32'h0, ST_BELOW, 1'b1));
        // three points, two components, one unit of tolerance
        add_cfg(CFG_POINT_COUNT, 32'd3);
        add_cfg(CFG_COMPONENTS, 32'd2);
        add_cfg(CFG_TOLERANCE, 32'h0001_0000);
        add_req(mk_req(REQ_WR_POINT, 8'd0, 3'd0, 32'hFFFF_0000, 32'h0, 32'h0));
        add_req(mk_req(REQ_WR_POINT, 8'd1, 3'd0, 32'h0000_0000, 32'h0, 32'h0));
        add_req(mk_req(REQ_WR_POINT, 8'd2, 3'd0, 32'h7FFE_0000, 32'h0, 32'h0));
        add_req(mk_req(REQ_WR_COMP, 8'd0, 3'd0, 32'h0, 32'h8000_0000, 32'h0));
        add_req(mk_req(REQ_WR_COMP, 8'd0, 3'd1, 32'h0, 32'h7FFF_FFFF, 32'h0));
        add_req(mk_req(REQ_WR_COMP, 8'd1, 3'd0, 32'h0, 32'h7FFF_FFFF, 32'h0));
        add_req(mk_req(REQ_WR_COMP, 8'd1, 3'd1, 32'h0, 32'h8000_0000, 32'h0));
        add_req(mk_req(REQ_WR_COMP, 8'd2, 3'd0, 32'h0, 32'h0000_0001, 32'h0));
        add_req(mk_req(REQ_WR_COMP, 8'd2, 3'd1, 32'h0, 32'hFFFF_FFFF, 32'h0));
        add_req(mk_req(REQ_QUERY, 8'd0, 3'd0, 32'h0, 32'h0, 32'hFFFE_0000));
        add_req(mk_req(REQ_QUERY, 8'd0, 3'd0, 32'h0, 32'h0, 32'hFFFD_FFFF));
        add_req(mk_req(REQ_QUERY, 8'd0, 3'd0, 32'h0, 32'h0, 32'hFFFF_8000));
        add_req(mk_req(REQ_QUERY, 8'd0, 3'd0, 32'h0, 32'h0, 32'h1234_5678));
        add_req(mk_req(REQ_QUERY, 8'd0, 3'd0, 32'h0, 32'h0, 32'h7FFF_FFFF));

        while (!aresetn) @(posedge aclk);
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                drain();
                cfg_write(directed_rows[k].cfg_idx, directed_rows[k].cfg_val);
            end else begin
                send_req(directed_rows[k].req, directed_rows[k].typed,
                         directed_rows[k].has_res, directed_rows[k].res);
            end
        end

        run_phase(32'd4, 32'd3, 32'h0000_8000, 1'b0, 14);
        run_phase(32'd0, 32'd8, 32'h0, 1'b0, 10);
        run_phase(32'd12, 32'd0, 32'h7FFF_FFFF, 1'b0, 12);
        run_phase(32'd2, 32'hF, 32'h0003_0000, 1'b0, 12);
        run_phase(32'd6, 32'd2, $urandom & 32'h000F_FFFF, 1'b1, 12);
        drain();
        calm = 1'b1;
        run_phase(32'd5, 32'd4, 32'h0001_0000, 1'b0, 14);

        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        $display("covered %0d queries and %0d table writes, %0d result beats checked",
                 queries_sent, writes_sent, results_seen);
        $display("register clamping, edge slack, unsorted tables and stalls; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("vector_linear_interpolation_table regression: pass");
        else
            $display("vector_linear_interpolation_table regression: fail");
        $finish;
    end

endmodule
